### design/cld_pkg.sv
// shared types, constants and helpers of the content-length deframer
package cld_pkg;

	// default widths and register resets
	localparam int LENGTH_BITS_DEF       = 24;
	localparam int HEADER_COUNT_BITS_DEF = 16;
	localparam int CFG_W                 = 24;
	localparam int HDR_CFG_W             = 16;
	localparam int HDR_RESET             = 8192;
	localparam int BODY_RESET            = 1048576;
	localparam int QUEUE_DEPTH           = 4;

	// configuration register indexes
	localparam logic [0:0] CFG_MAX_HEADER = 1'b0;
	localparam logic [0:0] CFG_MAX_BODY   = 1'b1;

	// characters
	localparam logic [7:0] CH_HT    = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_UP_Z  = 8'h5A;
	localparam logic [7:0] CASE_BIT = 8'h20;

	// length of the key "content-length"
	localparam logic [3:0] KEY_LEN = 4'd14;

	typedef enum logic [1:0] {
		PH_HEADER,
		PH_BODY,
		PH_FAILED
	} cld_phase_t;

	typedef enum logic [2:0] {
		LN_START,
		LN_LEAD,
		LN_NAME,
		LN_TRAIL,
		LN_VALUE,
		LN_SKIP
	} cld_line_t;

	typedef enum logic [2:0] {
		KIND_HEADER = 3'd0,
		KIND_BODY   = 3'd1,
		KIND_EMPTY  = 3'd2,
		KIND_ERROR  = 3'd3,
		KIND_DROP   = 3'd4
	} cld_kind_t;

	typedef enum logic [2:0] {
		ERR_NONE      = 3'd0,
		ERR_HDR_BIG   = 3'd1,
		ERR_MALFORMED = 3'd2,
		ERR_DUP       = 3'd3,
		ERR_INVALID   = 3'd4,
		ERR_TOO_LARGE = 3'd5,
		ERR_MISSING   = 3'd6
	} cld_err_t;

	// classified input item
	typedef struct packed {
		logic       close;
		logic [7:0] ch;
		logic [7:0] lower;
		logic       ws;
		logic       colon;
		logic       lf;
		logic       cr;
		logic       digit_ok;
		logic [3:0] digit_val;
	} cld_item_t;

	// result item
	typedef struct packed {
		cld_kind_t  kind;
		logic [7:0] body_byte;
		logic       last;
		cld_err_t   code;
	} cld_result_t;

	// lower-case key character at a position
	function automatic logic [7:0] key_char(input logic [3:0] idx);
		logic [7:0] c;
		unique case (idx)
			4'd0:    c = "c";
			4'd1:    c = "o";
			4'd2:    c = "n";
			4'd3:    c = "t";
			4'd4:    c = "e";
			4'd5:    c = "n";
			4'd6:    c = "t";
			4'd7:    c = "-";
			4'd8:    c = "l";
			4'd9:    c = "e";
			4'd10:   c = "n";
			4'd11:   c = "g";
			4'd12:   c = "t";
			4'd13:   c = "h";
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

### design/content_length_deframer.sv
// top level of the content-length deframer
// usage
//   input side is a queue: drive req_type and in_byte with push; an item is taken
//   at a clock edge with push high and full low. req_type 0 carries a data byte,
//   req_type 1 closes the link and gives no result item
//   result side is a queue too: while empty is low the oldest result stands on
//   out_kind, body_byte, last_of_message and error_code, and pop takes it
//   configuration: cfg_we with cfg_index 0 writes max_header_bytes, index 1
//   writes max_body_bytes; values are clamped to what the counters hold
// timing
//   one item per cycle while the result queue has room; a taken byte is
//   registered in the item queue, then its result in the result queue, and pop
//   can take it once it stands on the ports. the rate is set by the parser update in the back part
// reset
//   arst_n low empties both queues, loads the register defaults and puts the
//   parser at the start of a header; any error then sticks until reset
// stalls
//   when pop stays low the result queue fills, the back part halts and the
//   input queue fills behind it; full rises once both are full
module content_length_deframer #(
	parameter int LENGTH_BITS       = cld_pkg::LENGTH_BITS_DEF,
	parameter int HEADER_COUNT_BITS = cld_pkg::HEADER_COUNT_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [0:0]                cfg_index,
	input  logic [cld_pkg::CFG_W-1:0] cfg_wdata,
	input  logic                      push,
	output logic                      full,
	input  logic                      req_type,
	input  logic [7:0]                in_byte,
	output logic                      empty,
	input  logic                      pop,
	output logic [2:0]                out_kind,
	output logic [7:0]                body_byte,
	output logic                      last_of_message,
	output logic [2:0]                error_code
);

	localparam int ITEM_W = $bits(cld_pkg::cld_item_t);
	localparam int RES_W  = $bits(cld_pkg::cld_result_t);

	// front to back queue
	logic                 fq_wr_en;
	cld_pkg::cld_item_t   fq_wr_item;
	logic [ITEM_W-1:0]    fq_rd_data;
	logic                 fq_empty;
	logic                 fq_rd_en;
	cld_pkg::cld_item_t   fq_item;

	// back to result queue
	logic                 rq_full;
	logic                 rq_wr_en;
	cld_pkg::cld_result_t rq_wr_res;
	logic [RES_W-1:0]     rq_rd_data;
	cld_pkg::cld_result_t out_res;

	// classify each byte as it is taken
	cld_front u_front (
		.push     (push),
		.req_type (req_type),
		.in_byte  (in_byte),
		.q_full   (full),
		.q_wr_en  (fq_wr_en),
		.q_item   (fq_wr_item)
	);

	// decouples the classifier from the parser
	cld_queue #(
		.WIDTH (ITEM_W),
		.DEPTH (cld_pkg::QUEUE_DEPTH)
	) u_item_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (fq_wr_en),
		.wr_data (fq_wr_item),
		.full    (full),
		.rd_en   (fq_rd_en),
		.rd_data (fq_rd_data),
		.empty   (fq_empty)
	);

	assign fq_item = fq_rd_data;

	// parser, length check and body pass-through
	cld_back #(
		.LENGTH_BITS       (LENGTH_BITS),
		.HEADER_COUNT_BITS (HEADER_COUNT_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.item       (fq_item),
		.item_valid (!fq_empty),
		.item_take  (fq_rd_en),
		.res_full   (rq_full),
		.res_push   (rq_wr_en),
		.res        (rq_wr_res)
	);

	// result queue doubles as the output register
	cld_queue #(
		.WIDTH (RES_W),
		.DEPTH (cld_pkg::QUEUE_DEPTH)
	) u_result_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (rq_wr_en),
		.wr_data (rq_wr_res),
		.full    (rq_full),
		.rd_en   (pop),
		.rd_data (rq_rd_data),
		.empty   (empty)
	);

	assign out_res         = rq_rd_data;
	assign out_kind        = out_res.kind;
	assign body_byte       = out_res.body_byte;
	assign last_of_message = out_res.last;
	assign error_code      = out_res.code;

endmodule

### design/cld_queue.sv
// small first-word-fall-through queue on registers
module cld_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = cld_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	// DEPTH must be a power of two, at least two; the queue does not check it
	localparam int PTR_W = $clog2(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = count_q == (PTR_W + 1)'(DEPTH);
	assign empty   = count_q == '0;
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + (PTR_W + 1)'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - (PTR_W + 1)'(1);
			end
		end
	end

endmodule

### design/cld_front.sv
// front part: takes input items and classifies each byte
module cld_front (
	input  logic                push,
	input  logic                req_type,
	input  logic [7:0]          in_byte,
	input  logic                q_full,
	output logic                q_wr_en,
	output cld_pkg::cld_item_t  q_item
);

	logic is_upper;

	assign q_wr_en  = push && !q_full;
	assign is_upper = (in_byte >= cld_pkg::CH_UP_A) && (in_byte <= cld_pkg::CH_UP_Z);

	always_comb begin
		q_item.close     = req_type;
		q_item.ch        = in_byte;
		q_item.lower     = is_upper ? (in_byte | cld_pkg::CASE_BIT) : in_byte;
		q_item.ws        = (in_byte == cld_pkg::CH_SPACE) ||
		                   ((in_byte >= cld_pkg::CH_HT) && (in_byte <= cld_pkg::CH_CR));
		q_item.colon     = in_byte == cld_pkg::CH_COLON;
		q_item.lf        = in_byte == cld_pkg::CH_LF;
		q_item.cr        = in_byte == cld_pkg::CH_CR;
		q_item.digit_ok  = (in_byte >= cld_pkg::CH_ZERO) && (in_byte <= cld_pkg::CH_NINE);
		// low nibble of an ascii digit is its value
		q_item.digit_val = in_byte[3:0];
	end

endmodule

### design/cld_back.sv
// back part: header parser, length check and body pass-through
module cld_back #(
	parameter int LENGTH_BITS       = cld_pkg::LENGTH_BITS_DEF,
	parameter int HEADER_COUNT_BITS = cld_pkg::HEADER_COUNT_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [0:0]               cfg_index,
	input  logic [cld_pkg::CFG_W-1:0] cfg_wdata,
	input  cld_pkg::cld_item_t       item,
	input  logic                     item_valid,
	output logic                     item_take,
	input  logic                     res_full,
	output logic                     res_push,
	output cld_pkg::cld_result_t     res
);

	localparam int MB_W = (LENGTH_BITS < cld_pkg::CFG_W) ? LENGTH_BITS : cld_pkg::CFG_W;
	localparam int HB_W = (HEADER_COUNT_BITS < cld_pkg::HDR_CFG_W) ?
	                      HEADER_COUNT_BITS : cld_pkg::HDR_CFG_W;
	localparam int HC_W = HB_W + 1;
	localparam int AC_W = MB_W + 1;
	localparam int V_W  = AC_W + 4;
	localparam logic [31:0] HDR_LIMIT = 32'((64'd1 << HEADER_COUNT_BITS) - 64'd1);
	localparam logic [31:0] LEN_LIMIT = 32'((64'd1 << LENGTH_BITS) - 64'd1);
	localparam logic [HB_W-1:0] HDR_RST = HB_W'((32'(cld_pkg::HDR_RESET) > HDR_LIMIT) ?
	                                      HDR_LIMIT : 32'(cld_pkg::HDR_RESET));
	localparam logic [MB_W-1:0] BODY_RST = MB_W'((32'(cld_pkg::BODY_RESET) > LEN_LIMIT) ?
	                                       LEN_LIMIT : 32'(cld_pkg::BODY_RESET));

	logic [HB_W-1:0]     max_hdr_q;
	logic [MB_W-1:0]     max_body_q;
	cld_pkg::cld_phase_t phase_q, phase_d;
	logic [HC_W-1:0]     cnt_q, cnt_d;
	logic [1:0]          term_q, term_d;
	cld_pkg::cld_line_t  line_q, line_d;
	logic [3:0]          idx_q, idx_d;
	logic                match_q, match_d;
	logic [AC_W-1:0]     acc_q, acc_d;
	logic                vf_digit_q, vf_digit_d;
	logic                vf_bad_q, vf_bad_d;
	logic                vf_trail_q, vf_trail_d;
	cld_pkg::cld_err_t   pend_q, pend_d;
	logic                seen_q, seen_d;
	logic [MB_W-1:0]     rem_q, rem_d;

	logic [HB_W-1:0]     hdr_wr;
	logic [MB_W-1:0]     body_wr;
	logic                fire;
	logic [2:0]          m_next;
	logic [HC_W-1:0]     cnt_inc;
	logic [HC_W-1:0]     hdr_excess;
	logic                too_big;
	logic                term_hit;
	cld_pkg::cld_err_t   fail_code;
	logic                success;
	logic                name_hit;
	logic [V_W-1:0]      acc_v;
	logic [AC_W-1:0]     acc_cap;
	logic [AC_W-1:0]     acc_step;
	logic                body_last;
	logic                clr_line;
	logic                clr_hdr;
	logic                set_fail;

	// configuration, clamped to what the counters can hold
	assign hdr_wr  = (32'(cfg_wdata[cld_pkg::HDR_CFG_W-1:0]) > HDR_LIMIT) ?
	                 HDR_LIMIT[HB_W-1:0] : cfg_wdata[HB_W-1:0];
	assign body_wr = (32'(cfg_wdata) > LEN_LIMIT) ? LEN_LIMIT[MB_W-1:0] : cfg_wdata[MB_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_hdr_q  <= HDR_RST;
			max_body_q <= BODY_RST;
		end else if (cfg_we) begin
			if (cfg_index == cld_pkg::CFG_MAX_HEADER) begin
				max_hdr_q <= hdr_wr;
			end else begin
				max_body_q <= body_wr;
			end
		end
	end

	assign fire      = item_valid && !res_full;
	assign item_take = fire;
	assign res_push  = fire && !item.close;

	// terminator tracking and header size
	always_comb begin
		m_next = 3'd0;
		if (item.cr) begin
			m_next = (term_q == 2'd2) ? 3'd3 : 3'd1;
		end else if (item.lf && (term_q == 2'd1 || term_q == 2'd3)) begin
			m_next = {1'b0, term_q} + 3'd1;
		end
	end

	assign cnt_inc    = cnt_q + HC_W'(1);
	assign hdr_excess = cnt_inc - HC_W'(m_next);
	assign too_big    = hdr_excess > HC_W'(max_hdr_q);
	assign term_hit   = m_next == 3'd4;

	always_comb begin
		fail_code = cld_pkg::ERR_NONE;
		if (too_big) begin
			fail_code = cld_pkg::ERR_HDR_BIG;
		end else if (term_hit) begin
			if (pend_q != cld_pkg::ERR_NONE) begin
				fail_code = pend_q;
			end else if (!seen_q) begin
				fail_code = cld_pkg::ERR_MISSING;
			end
		end
	end

	assign success   = term_hit && (fail_code == cld_pkg::ERR_NONE);
	assign name_hit  = (idx_q < cld_pkg::KEY_LEN) && (cld_pkg::key_char(idx_q) == item.lower);
	assign body_last = rem_q == MB_W'(1);

	// decimal accumulate, saturated one above the limit
	assign acc_v    = (V_W'(acc_q) << 3) + (V_W'(acc_q) << 1) + V_W'(item.digit_val);
	assign acc_cap  = AC_W'(max_body_q) + AC_W'(1);
	assign acc_step = (acc_v > V_W'(acc_cap)) ? acc_cap : acc_v[AC_W-1:0];

	// next state
	always_comb begin
		phase_d    = phase_q;
		cnt_d      = cnt_q;
		term_d     = term_q;
		line_d     = line_q;
		idx_d      = idx_q;
		match_d    = match_q;
		acc_d      = acc_q;
		vf_digit_d = vf_digit_q;
		vf_bad_d   = vf_bad_q;
		vf_trail_d = vf_trail_q;
		pend_d     = pend_q;
		seen_d     = seen_q;
		rem_d      = rem_q;
		clr_line   = 1'b0;
		clr_hdr    = 1'b0;
		set_fail   = 1'b0;
		if (fire) begin
			if (item.close) begin
				if (phase_q != cld_pkg::PH_FAILED) begin
					phase_d = cld_pkg::PH_FAILED;
					clr_hdr = 1'b1;
					rem_d   = '0;
				end
			end else begin
				unique case (phase_q)
					cld_pkg::PH_BODY: begin
						rem_d = rem_q - MB_W'(1);
						if (body_last) begin
							phase_d = cld_pkg::PH_HEADER;
							clr_hdr = 1'b1;
						end
					end
					cld_pkg::PH_HEADER: begin
						if (fail_code != cld_pkg::ERR_NONE) begin
							phase_d  = cld_pkg::PH_FAILED;
							clr_hdr  = 1'b1;
							set_fail = 1'b1;
							rem_d    = '0;
						end else if (term_hit) begin
							clr_hdr = 1'b1;
							if (rem_q != '0) begin
								phase_d = cld_pkg::PH_BODY;
							end
						end else begin
							term_d = m_next[1:0];
							cnt_d  = cnt_inc;
							if (item.lf) begin
								// end of a header line
								clr_line = 1'b1;
								if (line_q inside {cld_pkg::LN_START, cld_pkg::LN_LEAD,
								                   cld_pkg::LN_NAME, cld_pkg::LN_TRAIL}) begin
									if (pend_q == cld_pkg::ERR_NONE) begin
										pend_d = cld_pkg::ERR_MALFORMED;
									end
								end else if (line_q == cld_pkg::LN_VALUE &&
								             pend_q == cld_pkg::ERR_NONE) begin
									if (seen_q) begin
										pend_d = cld_pkg::ERR_DUP;
									end else if (!vf_digit_q || vf_bad_q) begin
										pend_d = cld_pkg::ERR_INVALID;
									end else if (acc_q > AC_W'(max_body_q)) begin
										pend_d = cld_pkg::ERR_TOO_LARGE;
									end else begin
										seen_d = 1'b1;
										rem_d  = acc_q[MB_W-1:0];
									end
								end
							end else if (line_q inside {cld_pkg::LN_START, cld_pkg::LN_LEAD}) begin
								if (item.colon) begin
									if (line_q == cld_pkg::LN_START &&
									    pend_q == cld_pkg::ERR_NONE) begin
										pend_d = cld_pkg::ERR_MALFORMED;
									end
									line_d = cld_pkg::LN_SKIP;
								end else if (item.ws) begin
									line_d = cld_pkg::LN_LEAD;
								end else begin
									line_d = cld_pkg::LN_NAME;
									if (name_hit) begin
										idx_d = idx_q + 4'd1;
									end else begin
										match_d = 1'b0;
									end
								end
							end else if (line_q inside {cld_pkg::LN_NAME, cld_pkg::LN_TRAIL}) begin
								if (item.colon) begin
									if (match_q && idx_q == cld_pkg::KEY_LEN) begin
										line_d     = cld_pkg::LN_VALUE;
										acc_d      = '0;
										vf_digit_d = 1'b0;
										vf_bad_d   = 1'b0;
										vf_trail_d = 1'b0;
									end else begin
										line_d = cld_pkg::LN_SKIP;
									end
								end else if (item.ws) begin
									line_d = cld_pkg::LN_TRAIL;
								end else begin
									// a second word in the name spoils the match
									if (line_q == cld_pkg::LN_TRAIL) begin
										match_d = 1'b0;
									end
									line_d = cld_pkg::LN_NAME;
									if (name_hit) begin
										idx_d = idx_q + 4'd1;
									end else begin
										match_d = 1'b0;
									end
								end
							end else if (line_q == cld_pkg::LN_VALUE) begin
								if (item.ws) begin
									if (vf_digit_q) begin
										vf_trail_d = 1'b1;
									end
								end else if (item.digit_ok) begin
									if (vf_trail_q) begin
										vf_bad_d = 1'b1;
									end else begin
										acc_d      = acc_step;
										vf_digit_d = 1'b1;
									end
								end else begin
									vf_bad_d = 1'b1;
								end
							end
						end
					end
					default: begin
					end
				endcase
			end
		end
		if (clr_hdr) begin
			cnt_d    = '0;
			term_d   = 2'd0;
			pend_d   = cld_pkg::ERR_NONE;
			seen_d   = 1'b0;
			clr_line = 1'b1;
		end
		if (set_fail) begin
			pend_d = fail_code;
		end
		if (clr_line) begin
			line_d     = cld_pkg::LN_START;
			idx_d      = 4'd0;
			match_d    = 1'b1;
			acc_d      = '0;
			vf_digit_d = 1'b0;
			vf_bad_d   = 1'b0;
			vf_trail_d = 1'b0;
		end
	end

	// result of the item in hand
	always_comb begin
		res.kind      = cld_pkg::KIND_HEADER;
		res.body_byte = 8'h00;
		res.last      = 1'b0;
		res.code      = cld_pkg::ERR_NONE;
		unique case (phase_q)
			cld_pkg::PH_FAILED: begin
				res.kind = cld_pkg::KIND_DROP;
				res.code = pend_q;
			end
			cld_pkg::PH_BODY: begin
				res.kind      = cld_pkg::KIND_BODY;
				res.body_byte = item.ch;
				res.last      = body_last;
			end
			cld_pkg::PH_HEADER: begin
				if (fail_code != cld_pkg::ERR_NONE) begin
					res.kind = cld_pkg::KIND_ERROR;
					res.code = fail_code;
				end else if (success && rem_q == '0) begin
					res.kind = cld_pkg::KIND_EMPTY;
					res.last = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= cld_pkg::PH_HEADER;
			cnt_q      <= '0;
			term_q     <= 2'd0;
			line_q     <= cld_pkg::LN_START;
			idx_q      <= 4'd0;
			match_q    <= 1'b1;
			acc_q      <= '0;
			vf_digit_q <= 1'b0;
			vf_bad_q   <= 1'b0;
			vf_trail_q <= 1'b0;
			pend_q     <= cld_pkg::ERR_NONE;
			seen_q     <= 1'b0;
			rem_q      <= '0;
		end else begin
			phase_q    <= phase_d;
			cnt_q      <= cnt_d;
			term_q     <= term_d;
			line_q     <= line_d;
			idx_q      <= idx_d;
			match_q    <= match_d;
			acc_q      <= acc_d;
			vf_digit_q <= vf_digit_d;
			vf_bad_q   <= vf_bad_d;
			vf_trail_q <= vf_trail_d;
			pend_q     <= pend_d;
			seen_q     <= seen_d;
			rem_q      <= rem_d;
		end
	end

	a_body_remaining: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == cld_pkg::PH_BODY |-> rem_q != '0)
		else $error("body phase with nothing left to pass");

	a_failed_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == cld_pkg::PH_FAILED |-> (line_q == cld_pkg::LN_START && cnt_q == '0 &&
		                                   !seen_q && term_q == 2'd0))
		else $error("parser state left over after failure");

	a_error_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		(res_push && res.kind == cld_pkg::KIND_ERROR) |=>
		(phase_q == cld_pkg::PH_FAILED && pend_q != cld_pkg::ERR_NONE))
		else $error("reported error did not stick");

	a_term_in_count: assert property (@(posedge clk) disable iff (!arst_n)
		HC_W'(term_q) <= cnt_q)
		else $error("terminator match longer than header");

endmodule
